// File: hw/rtl/mpwm_pkg.sv
// mpwm_pkg: constants, codes, types and the channel level rule of the PWM generator.
// Depends on nothing; used by the interfaces, the top level, the skid stage and the checker.
`default_nettype none

package mpwm_pkg;

  localparam int unsigned NUM_CHANNELS = 16;
  localparam int unsigned COUNT_BITS   = 12;
  localparam int unsigned WORD_W       = COUNT_BITS + 1;
  localparam int unsigned LEVEL_W      = 16;
  localparam int unsigned POS_W        = 12;
  localparam int unsigned ACTION_W     = 3;
  localparam int unsigned CHANNEL_W    = 4;
  localparam int unsigned PRESCALE_W   = 8;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [APB_ADDR_W-1:0] REG_PRESCALE_ADDR = '0;

  localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = PRESCALE_W'(30);
  localparam logic [PRESCALE_W-1:0] PRESCALE_MIN   = PRESCALE_W'(3);

  localparam logic [WORD_W-1:0] FULL_FLAG = WORD_W'(1) << COUNT_BITS;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK    = 3'd0,
    ACT_WRITE   = 3'd1,
    ACT_ALL_OFF = 3'd2,
    ACT_SLEEP   = 3'd3,
    ACT_WAKE    = 3'd4
  } action_e;

  typedef struct packed {
    logic [LEVEL_W-1:0] levels;
    logic [POS_W-1:0]   period_position;
    logic               sleeping;
  } result_t;

  // Level of one channel at counter position pos.
  function automatic logic channel_level(input logic [WORD_W-1:0]     on_w,
                                         input logic [WORD_W-1:0]     off_w,
                                         input logic [COUNT_BITS-1:0] pos);
    logic [COUNT_BITS-1:0] a;
    logic [COUNT_BITS-1:0] b;
    logic                  lvl;
    a = on_w[COUNT_BITS-1:0];
    b = off_w[COUNT_BITS-1:0];
    if (off_w[COUNT_BITS]) begin
      lvl = 1'b0;
    end else if (on_w[COUNT_BITS]) begin
      lvl = 1'b1;
    end else if (a == b) begin
      lvl = 1'b0;
    end else if (a < b) begin
      lvl = (pos >= a) && (pos < b);
    end else begin
      lvl = (pos >= a) || (pos < b);
    end
    return lvl;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mpwm_if.sv
// mpwm_in_if / mpwm_out_if: valid/ready channels for command words and result words.
// Depends on mpwm_pkg for field widths.
`default_nettype none

interface mpwm_in_if;
  logic                                valid;
  logic                                ready;
  logic [mpwm_pkg::ACTION_W-1:0]       action;
  logic [mpwm_pkg::CHANNEL_W-1:0]      channel;
  logic [mpwm_pkg::WORD_W-1:0]         on_count;
  logic [mpwm_pkg::WORD_W-1:0]         off_value;

  modport source (output valid, action, channel, on_count, off_value, input ready);
  modport sink   (input valid, action, channel, on_count, off_value, output ready);
endinterface

interface mpwm_out_if;
  logic                                valid;
  logic                                ready;
  logic [mpwm_pkg::LEVEL_W-1:0]        levels;
  logic [mpwm_pkg::POS_W-1:0]          period_position;
  logic                                sleeping;

  modport source (output valid, levels, period_position, sleeping, input ready);
  modport sink   (input valid, levels, period_position, sleeping, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/mpwm_skid.sv
// mpwm_skid: two-entry output stage (result register plus skid register).
// Depends on mpwm_pkg (result_t) and mpwm_out_if.
`default_nettype none

module mpwm_skid (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  input  mpwm_pkg::result_t    push_data_i,
  output logic                 push_ready_o,
  mpwm_out_if.source           out_o
);

  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  mpwm_pkg::result_t out_data_q, out_data_d;
  mpwm_pkg::result_t skid_data_q, skid_data_d;
  logic              push;

  // Free while the skid entry is empty.
  assign push_ready_o = !skid_valid_q;
  assign push         = push_valid_i && !skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (!out_valid_q || out_o.ready) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push;
        if (push) begin
          out_data_d = push_data_i;
        end
      end
    end else if (push) begin
      skid_valid_d = 1'b1;
      skid_data_d  = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.levels          = out_data_q.levels;
  assign out_o.period_position = out_data_q.period_position;
  assign out_o.sleeping        = out_data_q.sleeping;

endmodule

`default_nettype wire

// File: hw/rtl/multichannel_pwm_generator.sv
// Multichannel PWM generator: one command word in, one result word out, per cycle while
// neither side stalls. Each result word is registered in the output stage. Throughput:
// one command word per cycle while in_i.ready is high. When out_o stalls, the two-entry
// output stage takes one more word into skid, then in_i.ready drops until skid empties.
// Reset: prescale 30, counters zero, all channels full off, block asleep, no words held.
// Depends on mpwm_pkg, mpwm_if (mpwm_in_if, mpwm_out_if) and mpwm_skid.
`default_nettype none

module multichannel_pwm_generator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // APB register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mpwm_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [mpwm_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [mpwm_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  // word channels
  mpwm_in_if.sink                           in_i,
  mpwm_out_if.source                        out_o
);

  localparam int unsigned NCH = mpwm_pkg::NUM_CHANNELS;
  localparam int unsigned CB  = mpwm_pkg::COUNT_BITS;
  localparam int unsigned WW  = mpwm_pkg::WORD_W;
  localparam int unsigned PW  = mpwm_pkg::PRESCALE_W;
  localparam int unsigned AW  = mpwm_pkg::APB_ADDR_W;

  // ---------------------------------------------------------------------------
  // Register port: single prescale register, no wait states.
  // Decoded on the word index; the byte lane bits are ignored.
  // ---------------------------------------------------------------------------
  logic [PW-1:0] prescale_q;
  logic          reg_sel;
  logic          reg_wr;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[AW-1:2] == mpwm_pkg::REG_PRESCALE_ADDR[AW-1:2]);
  assign reg_wr  = psel && penable && pwrite && reg_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_q <= mpwm_pkg::PRESCALE_RESET;
    end else if (reg_wr) begin
      prescale_q <= pwdata[PW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata[PW-1:0] = prescale_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Core state
  // ---------------------------------------------------------------------------
  logic [PW-1:0]  div_q, div_d;
  logic [CB-1:0]  pos_q, pos_d;
  logic           asleep_q, asleep_d;
  logic [WW-1:0]  on_q  [NCH];
  logic [WW-1:0]  on_d  [NCH];
  logic [WW-1:0]  off_q [NCH];
  logic [WW-1:0]  off_d [NCH];

  logic              accept;
  logic              push_ready;
  logic [PW-1:0]     eff_prescale;
  mpwm_pkg::result_t result;

  assign accept       = in_i.valid && push_ready;
  assign in_i.ready   = push_ready;
  // prescale below the minimum behaves as the minimum
  assign eff_prescale = (prescale_q < mpwm_pkg::PRESCALE_MIN) ? mpwm_pkg::PRESCALE_MIN
                                                                : prescale_q;

  always_comb begin
    div_d    = div_q;
    pos_d    = pos_q;
    asleep_d = asleep_q;
    for (int i = 0; i < NCH; i++) begin
      on_d[i]  = on_q[i];
      off_d[i] = off_q[i];
    end
    if (accept) begin
      case (mpwm_pkg::action_e'(in_i.action))
        mpwm_pkg::ACT_TICK: begin
          // ticks while asleep are dropped
          if (!asleep_q) begin
            if (div_q >= eff_prescale) begin
              div_d = '0;
              pos_d = pos_q + CB'(1);
            end else begin
              div_d = div_q + PW'(1);
            end
          end
        end
        mpwm_pkg::ACT_WRITE: begin
          // one write enable per lane
          for (int i = 0; i < NCH; i++) begin
            if (32'(in_i.channel) == i) begin
              on_d[i]  = in_i.on_count;
              off_d[i] = in_i.off_value;
            end
          end
        end
        mpwm_pkg::ACT_ALL_OFF: begin
          for (int i = 0; i < NCH; i++) begin
            on_d[i]  = '0;
            off_d[i] = mpwm_pkg::FULL_FLAG;
          end
        end
        mpwm_pkg::ACT_SLEEP: begin
          asleep_d = 1'b1;
        end
        mpwm_pkg::ACT_WAKE: begin
          // wake restarts both counters even when already awake
          asleep_d = 1'b0;
          div_d    = '0;
          pos_d    = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Result reflects the state after the command: one comparator pair per lane.
  always_comb begin
    result = '0;
    result.period_position = mpwm_pkg::POS_W'(pos_d);
    result.sleeping        = asleep_d;
    for (int i = 0; i < NCH && i < mpwm_pkg::LEVEL_W; i++) begin
      result.levels[i] = !asleep_d && mpwm_pkg::channel_level(on_d[i], off_d[i], pos_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q    <= '0;
      pos_q    <= '0;
      asleep_q <= 1'b1;
      for (int i = 0; i < NCH; i++) begin
        on_q[i]  <= '0;
        off_q[i] <= mpwm_pkg::FULL_FLAG;
      end
    end else begin
      div_q    <= div_d;
      pos_q    <= pos_d;
      asleep_q <= asleep_d;
      for (int i = 0; i < NCH; i++) begin
        on_q[i]  <= on_d[i];
        off_q[i] <= off_d[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage
  // ---------------------------------------------------------------------------
  mpwm_skid u_skid (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_i.valid),
    .push_data_i  (result),
    .push_ready_o (push_ready),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/mpwm_checker.sv
// mpwm_checker: port-level assertions on the PWM generator, bound to its top level.
// Depends on mpwm_pkg and multichannel_pwm_generator.
`default_nettype none

module mpwm_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [mpwm_pkg::LEVEL_W-1:0]    levels_i,
  input  logic [mpwm_pkg::POS_W-1:0]      period_position_i,
  input  logic                            sleeping_i
);

  // while asleep every channel is low
  a_sleep_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && sleeping_i) |-> (levels_i == '0))
    else $error("levels set while sleeping");

  // input backpressure only when a result word is pending
  a_ready_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("in ready low with empty output");

  // an accepted word into an empty output shows up next cycle
  a_accept_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && !out_valid_i) |=> out_valid_i)
    else $error("accepted word did not reach output");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(levels_i) && $stable(period_position_i) &&
       $stable(sleeping_i)))
    else $error("stalled result word changed");

endmodule

bind multichannel_pwm_generator mpwm_checker u_mpwm_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .levels_i          (out_o.levels),
  .period_position_i (out_o.period_position),
  .sleeping_i        (out_o.sleeping)
);

`default_nettype wire

// File: dv/tb_multichannel_pwm_generator.sv
// Self-checking testbench for the multichannel PWM generator: command words in, result words
// checked against an in-bench model of prescaler, period counter and channel windows.
// Depends on mpwm_pkg, mpwm_if and the multichannel_pwm_generator RTL.
`default_nettype none

module tb_multichannel_pwm_generator;

  localparam int unsigned HOLDOFF_CYCLES = 300;   // long sink stall, fills the skid stage
  localparam int unsigned WATCHDOG_LIMIT = 4000;  // cycles with no word moving on either side
  localparam int unsigned PHASE_WORDS    = 180;   // random words per prescale setting
  localparam int unsigned RUN_WORDS      = 250;   // tick-heavy words at the fastest rate

  localparam int unsigned PSW = mpwm_pkg::PRESCALE_W;
  localparam int unsigned CB  = mpwm_pkg::COUNT_BITS;
  localparam int unsigned WW  = mpwm_pkg::WORD_W;
  localparam int unsigned AW  = mpwm_pkg::ACTION_W;
  localparam int unsigned CW  = mpwm_pkg::CHANNEL_W;

  // Model of the generator: it holds its own copy of every register and counter and queues
  // the result word that each accepted command word must produce.
  class pwm_scoreboard;
    logic [PSW-1:0]        prescale;
    logic [PSW-1:0]        divider;
    logic [CB-1:0]         position;
    logic [WW-1:0]         on_w  [mpwm_pkg::NUM_CHANNELS];
    logic [WW-1:0]         off_w [mpwm_pkg::NUM_CHANNELS];
    bit                    asleep;
    mpwm_pkg::result_t     expected_q[$];
    int unsigned           errors;

    function new();
      prescale = mpwm_pkg::PRESCALE_RESET;
      divider  = '0;
      position = '0;
      asleep   = 1'b1;
      errors   = 0;
      clear_channels();
    endfunction

    function void clear_channels();
      foreach (on_w[i]) begin
        on_w[i]  = '0;
        off_w[i] = mpwm_pkg::FULL_FLAG;
      end
    endfunction

    // High while the distance from the rising count is shorter than the window; a window
    // of zero length (equal counts) never fires, and wrap-around falls out of the modulo.
    function bit output_high(logic [WW-1:0] on_word, logic [WW-1:0] off_word,
                             logic [CB-1:0] pos);
      logic [CB-1:0] delta;
      logic [CB-1:0] span;
      delta = pos - on_word[CB-1:0];
      span  = off_word[CB-1:0] - on_word[CB-1:0];
      if (off_word[CB]) return 1'b0;
      if (on_word[CB]) return 1'b1;
      return delta < span;
    endfunction

    function void set_prescale(logic [PSW-1:0] value);
      prescale = value;
    endfunction

    function void note_word(logic [AW-1:0] act, logic [CW-1:0] ch,
                            logic [WW-1:0] on_word, logic [WW-1:0] off_word);
      logic [PSW-1:0]    limit;
      mpwm_pkg::result_t res;
      limit = (prescale < mpwm_pkg::PRESCALE_MIN) ? mpwm_pkg::PRESCALE_MIN : prescale;
      case (act)
        mpwm_pkg::ACT_TICK: begin
          if (!asleep) begin
            if (divider >= limit) begin
              divider  = '0;
              position = position + CB'(1);
            end else begin
              divider = divider + PSW'(1);
            end
          end
        end
        mpwm_pkg::ACT_WRITE: begin
          on_w[ch]  = on_word;
          off_w[ch] = off_word;
        end
        mpwm_pkg::ACT_ALL_OFF: clear_channels();
        mpwm_pkg::ACT_SLEEP:   asleep = 1'b1;
        mpwm_pkg::ACT_WAKE: begin
          asleep   = 1'b0;
          divider  = '0;
          position = '0;
        end
        default: ;
      endcase
      res.levels = '0;
      for (int i = 0; i < mpwm_pkg::NUM_CHANNELS; i++) begin
        if (!asleep && output_high(on_w[i], off_w[i], position)) res.levels[i] = 1'b1;
      end
      res.period_position = position;
      res.sleeping        = asleep;
      expected_q.push_back(res);
    endfunction

    function void check_word(mpwm_pkg::result_t got);
      mpwm_pkg::result_t exp_w;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing expected: %h", $time, got);
        return;
      end
      exp_w = expected_q.pop_front();
      if (got.levels !== exp_w.levels || got.period_position !== exp_w.period_position ||
          got.sleeping !== exp_w.sleeping) begin
        errors++;
        $display("%0t: mismatch levels %h/%h position %0d/%0d sleeping %b/%b (exp/act)",
                 $time, exp_w.levels, got.levels, exp_w.period_position,
                 got.period_position, exp_w.sleeping, got.sleeping);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                              clk_i;
  logic                              rst_ni;
  logic                              psel;
  logic                              penable;
  logic                              pwrite;
  logic [mpwm_pkg::APB_ADDR_W-1:0]   paddr;
  logic [mpwm_pkg::APB_DATA_W-1:0]   pwdata;
  logic [mpwm_pkg::APB_DATA_W-1:0]   prdata;
  logic                              pready;

  mpwm_in_if  in_if ();
  mpwm_out_if out_if ();

  pwm_scoreboard sb = new();
  bit            steady;       // sender offers back to back while set
  bit            holdoff_req;  // asks the sink for one long stall
  int unsigned   idle_cycles;

  multichannel_pwm_generator u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_if),
    .out_o   (out_if)
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Both channels are sampled at the rising edge, before any update of that edge lands.
  // The command word is noted first so a same-edge result would still find it queued.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready)
        sb.note_word(in_if.action, in_if.channel, in_if.on_count, in_if.off_value);
      if (out_if.valid && out_if.ready)
        sb.check_word('{levels: out_if.levels, period_position: out_if.period_position,
                        sleeping: out_if.sleeping});
    end
  end

  // Watchdog: counts cycles in which no word moves on either channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("multichannel_pwm_generator verification failed");
      $finish;
    end
  end

  // Result sink: random ready pattern, calm stretches, and one long stall on request.
  initial begin : result_sink
    int unsigned stall;
    bit          calm;
    calm = 1'b0;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        stall = HOLDOFF_CYCLES;
      end else begin
        if ($urandom_range(63) == 0) calm = !calm;
        stall = calm ? 0 : pick_gap();
      end
      repeat (stall) begin
        @(posedge clk_i);
        out_if.ready <= 1'b0;
      end
      @(posedge clk_i);
      out_if.ready <= 1'b1;
    end
  end

  // Offers one command word and returns at the edge that takes it. Always entered at an
  // edge; valid is assigned at most once per edge.
  task automatic send_word(input logic [AW-1:0] act, input logic [CW-1:0] ch,
                           input logic [WW-1:0] on_word, input logic [WW-1:0] off_word);
    int unsigned gap;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_if.valid     <= 1'b0;
      in_if.action    <= AW'($urandom);
      in_if.on_count  <= WW'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.action    <= act;
    in_if.channel   <= ch;
    in_if.on_count  <= on_word;
    in_if.off_value <= off_word;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Random command word. Half the channel writes place their window right around the
  // current count so that edges actually get crossed by the ticks that follow.
  task automatic send_random(input bit sweep);
    int unsigned     r;
    logic [AW-1:0]   act;
    logic [CW-1:0]   ch;
    logic [WW-1:0]   on_word;
    logic [WW-1:0]   off_word;
    r        = $urandom_range(99);
    ch       = CW'($urandom);
    on_word  = WW'($urandom);
    off_word = WW'($urandom);
    if (sweep) act = (r < 96) ? mpwm_pkg::ACT_TICK : mpwm_pkg::ACT_WRITE;
    else if (r < 64) act = mpwm_pkg::ACT_TICK;
    else if (r < 86) act = mpwm_pkg::ACT_WRITE;
    else if (r < 88) act = mpwm_pkg::ACT_ALL_OFF;
    else if (r < 91) act = mpwm_pkg::ACT_SLEEP;
    else if (r < 96) act = mpwm_pkg::ACT_WAKE;
    else act = AW'($urandom_range(7, 5));   // unused codes
    if (act == mpwm_pkg::ACT_WRITE && $urandom_range(1) == 1) begin
      on_word  = {($urandom_range(9) == 0), sb.position + CB'($urandom_range(6))};
      off_word = {($urandom_range(9) == 0), on_word[CB-1:0] + CB'($urandom_range(12))};
      if ($urandom_range(3) == 0) off_word[CB-1:0] = on_word[CB-1:0] - CB'(3);
    end
    send_word(act, ch, on_word, off_word);
  endtask

  // Stops offering and waits until every queued result has come back.
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle; the register takes the value at the edge
  // where the access is completed.
  task automatic write_prescale(input logic [PSW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= mpwm_pkg::REG_PRESCALE_ADDR;
    pwdata  <= {(mpwm_pkg::APB_DATA_W-PSW)'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_prescale(value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin : stimulus
    logic [PSW-1:0] settings [9];
    rst_ni          <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    in_if.valid     <= 1'b0;
    in_if.action    <= mpwm_pkg::ACT_TICK;
    in_if.channel   <= '0;
    in_if.on_count  <= '0;
    in_if.off_value <= '0;
    steady          = 1'b0;
    holdoff_req     = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset state, asleep, at the reset prescale.
    send_word(mpwm_pkg::ACT_TICK, '0, '0, '0);              // tick while asleep is dropped
    send_word(mpwm_pkg::ACT_SLEEP, '0, '0, '0);             // sleep while already asleep
    send_word(AW'(5), 4'hf, 13'h1fff, 13'h1fff);            // unused codes do nothing
    send_word(AW'(7), 4'h0, 13'h0, 13'h0);
    send_word(mpwm_pkg::ACT_WRITE, 4'd0, 13'h0000, 13'h0000);   // equal counts, always low
    send_word(mpwm_pkg::ACT_WAKE, '0, '0, '0);
    send_word(mpwm_pkg::ACT_WRITE, 4'd1, 13'h1000, 13'h0005);   // full on
    send_word(mpwm_pkg::ACT_WRITE, 4'd2, 13'h1fff, 13'h1fff);   // full off wins over full on
    send_word(mpwm_pkg::ACT_WRITE, 4'd15, 13'h0fff, 13'h0000);  // wraps, high only at top
    send_word(mpwm_pkg::ACT_WRITE, 4'd3, 13'h0000, 13'h0fff);   // widest plain window
    send_word(mpwm_pkg::ACT_WRITE, 4'd4, 13'h000a, 13'h0002);   // on past off, wraps
    send_word(mpwm_pkg::ACT_WAKE, '0, '0, '0);              // wake while awake clears counters
    send_word(mpwm_pkg::ACT_ALL_OFF, '0, '0, '0);
    send_word(mpwm_pkg::ACT_SLEEP, '0, '0, '0);
    settle();

    // Shortest legal prescale: watch the counter step.
    write_prescale(PSW'(3));
    send_word(mpwm_pkg::ACT_WAKE, '0, '0, '0);
    send_word(mpwm_pkg::ACT_WRITE, 4'd7, 13'h0001, 13'h0003);
    repeat (9) send_word(mpwm_pkg::ACT_TICK, '0, '0, '0);
    settle();

    // Random phases over several prescale settings. The largest is followed by the
    // smallest so the divider is far above the new limit when it drops; values under
    // the minimum are clamped by the block.
    settings = '{8'd255, 8'd3, 8'd0, 8'd1, 8'd2, 8'd30, 8'd4, 8'd128, 8'd0};
    settings[6] = PSW'($urandom);
    foreach (settings[p]) begin
      write_prescale(settings[p]);
      steady = (p % 2 == 1);
      if (p == 1) holdoff_req = 1'b1;   // sender keeps offering into a stalled sink
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(47) == 0) steady = !steady;
        send_random(1'b0);
      end
      settle();                          // sender pauses until the queue is empty
    end

    // Tick-heavy run at the fastest rate, with windows placed around the count.
    write_prescale(PSW'(3));
    send_word(mpwm_pkg::ACT_WAKE, '0, '0, '0);
    for (int n = 0; n < RUN_WORDS; n++) begin
      if ($urandom_range(63) == 0) steady = !steady;
      send_random(1'b1);
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("multichannel_pwm_generator verification clean");
    end else begin
      $display("multichannel_pwm_generator verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
hw/rtl/mpwm_pkg.sv
hw/rtl/mpwm_if.sv
hw/rtl/mpwm_skid.sv
hw/rtl/multichannel_pwm_generator.sv
hw/rtl/mpwm_checker.sv
dv/tb_multichannel_pwm_generator.sv
